// ===== rtl/core/dpod_pkg.sv =====
// Shared types, constants and calendar tables for the date period overlap block.
package dpod_pkg;

    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned SER_W   = 22;
    localparam int unsigned CUM_W   = 9;
    localparam int unsigned NUM_DATES = 4;
    localparam int unsigned IDX_W   = 2;

    localparam int unsigned YEAR_MAX   = 9999;
    localparam int unsigned DAYS_YEAR  = 365;
    // Reciprocal of 25 scaled by 2**16; exact floor for dividends below 4096
    localparam int unsigned RECIP_25   = 2622;
    localparam int unsigned RECIP_SHIFT = 16;
    localparam int unsigned PROD_W     = 24;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } t_date;

    // Commands from the sequencer to the datapath
    typedef struct packed {
        logic             load;
        logic             conv;
        logic [IDX_W-1:0] idx;
        logic             window;
        logic             finish;
    } t_cmd;

    // Days in the month; 0 for a month code outside January..December
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        unique case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
            4'd2:                                        len = leap ? 5'd29 : 5'd28;
            default:                                     len = 5'd0;
        endcase
        return len;
    endfunction

    // Days of the year that lie before the first of the month
    function automatic logic [CUM_W-1:0] days_before(input logic [MONTH_W-1:0] month,
                                                     input logic leap);
        logic [CUM_W-1:0] cum;
        unique case (month)
            4'd1:    cum = 9'd0;
            4'd2:    cum = 9'd31;
            4'd3:    cum = 9'd59;
            4'd4:    cum = 9'd90;
            4'd5:    cum = 9'd120;
            4'd6:    cum = 9'd151;
            4'd7:    cum = 9'd181;
            4'd8:    cum = 9'd212;
            4'd9:    cum = 9'd243;
            4'd10:   cum = 9'd273;
            4'd11:   cum = 9'd304;
            4'd12:   cum = 9'd334;
            default: cum = 9'd0;
        endcase
        if (leap && (month > MONTH_FEB)) begin
            cum = cum + 9'd1;
        end
        return cum;
    endfunction

endpackage

// ===== rtl/core/dpod_ctrl.sv =====
// Sequencer: steps the four dates through the converter, then the window and result.
module dpod_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    output logic            o_done,
    output dpod_pkg::t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_DRAIN,
        S_WINDOW,
        S_FINISH
    } t_state;

    t_state                     r_state, n_state;
    logic [dpod_pkg::IDX_W-1:0] r_cnt, n_cnt;
    logic                       r_busy, n_busy;
    logic                       r_done, n_done;
    logic                       w_accept;

    assign w_accept = start && !r_busy;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_CONV;
                    n_cnt   = '0;
                    n_busy  = 1'b1;
                end
            end
            S_CONV: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == dpod_pkg::IDX_W'(dpod_pkg::NUM_DATES - 1)) begin
                    n_state = S_DRAIN;
                    n_cnt   = '0;
                end
            end
            S_DRAIN: begin
                // wait for the last date to leave the two later converter stages
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == dpod_pkg::IDX_W'(1)) begin
                    n_state = S_WINDOW;
                end
            end
            S_WINDOW: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                n_state = S_IDLE;
                n_busy  = 1'b0;
                n_done  = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
                n_busy  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_busy  <= n_busy;
            r_done  <= n_done;
        end
    end

    assign busy         = r_busy;
    assign o_done       = r_done;
    assign o_cmd.load   = w_accept;
    assign o_cmd.conv   = (r_state == S_CONV);
    assign o_cmd.idx    = r_cnt;
    assign o_cmd.window = (r_state == S_WINDOW);
    assign o_cmd.finish = (r_state == S_FINISH);

endmodule

// ===== rtl/core/dpod_dp.sv =====
// Datapath: date store, three-stage serial-day converter, window and result registers.
module dpod_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  dpod_pkg::t_cmd                 i_cmd,
    input  dpod_pkg::t_date                i_date0,
    input  dpod_pkg::t_date                i_date1,
    input  dpod_pkg::t_date                i_date2,
    input  dpod_pkg::t_date                i_date3,
    output logic [dpod_pkg::SER_W-1:0]     o_overlap_days,
    output logic                           o_has_overlap,
    output logic                           o_date_invalid
);

    localparam int unsigned YW = dpod_pkg::YEAR_W;
    localparam int unsigned QW = dpod_pkg::YEAR_W - 2;
    localparam int unsigned PW = dpod_pkg::PROD_W;
    localparam int unsigned SW = dpod_pkg::SER_W;
    localparam int unsigned CW = PW - dpod_pkg::RECIP_SHIFT;

    dpod_pkg::t_date r_date [dpod_pkg::NUM_DATES];

    // stage A registers
    logic                       r_a_vld;
    logic [dpod_pkg::IDX_W-1:0] r_a_idx;
    dpod_pkg::t_date            r_a_date;
    logic [PW-1:0]              r_a_prodp;
    logic [PW-1:0]              r_a_prody;

    // stage B registers
    logic                       r_b_vld;
    logic [dpod_pkg::IDX_W-1:0] r_b_idx;
    dpod_pkg::t_date            r_b_date;
    logic [SW-1:0]              r_b_base;
    logic                       r_b_leap;

    // stage C results
    logic [SW-1:0]              r_ser [dpod_pkg::NUM_DATES];
    logic                       r_bad;
    logic [SW-1:0]              r_lo;
    logic [SW-1:0]              r_hi;

    dpod_pkg::t_date   w_sel;
    logic [YW-1:0]     w_p;
    logic [QW-1:0]     w_q4p, w_q4y;
    logic [CW-1:0]     w_c100p, w_c100y;
    logic [PW-1:0]     w_base;
    logic [12:0]       w_y100;
    logic              w_div4, w_div100, w_leap;
    logic [YW-1:0]     w_bp;
    logic [dpod_pkg::DAY_W-1:0] w_dim;
    logic [dpod_pkg::CUM_W-1:0] w_cum;
    logic              w_ok;
    logic [SW-1:0]     w_serial;
    logic [SW-1:0]     w_diff;

    // Stage A: year minus one, and quarter years scaled by the reciprocal of 25
    always_comb begin
        w_sel = r_date[i_cmd.idx];
        w_p   = w_sel.year - YW'(1);
        w_q4p = w_p[YW-1:2];
        w_q4y = w_sel.year[YW-1:2];
    end

    // Stage B: century counts, leap flag and days of the whole years before
    always_comb begin
        w_bp     = r_a_date.year - YW'(1);
        w_c100p  = r_a_prodp[PW-1:dpod_pkg::RECIP_SHIFT];
        w_c100y  = r_a_prody[PW-1:dpod_pkg::RECIP_SHIFT];
        w_y100   = 13'(w_c100y) * 13'(25);
        w_div4   = (r_a_date.year[1:0] == 2'b00);
        w_div100 = w_div4 && (w_y100 == 13'(r_a_date.year[YW-1:2]));
        w_leap   = w_div4 && (!w_div100 || (w_c100y[1:0] == 2'b00));
        w_base   = PW'(w_bp) * PW'(dpod_pkg::DAYS_YEAR) + PW'(w_bp[YW-1:2])
                 - PW'(w_c100p) + PW'(w_c100p[CW-1:2]);
    end

    // Stage C: validity check and day of the year
    always_comb begin
        w_dim    = dpod_pkg::month_len(r_b_date.month, r_b_leap);
        w_cum    = dpod_pkg::days_before(r_b_date.month, r_b_leap);
        w_ok     = (r_b_date.year != '0) && (r_b_date.year <= YW'(dpod_pkg::YEAR_MAX))
                && (r_b_date.day != '0) && (r_b_date.day <= w_dim);
        w_serial = r_b_base + SW'(w_cum) + SW'(r_b_date.day);
        w_diff   = r_hi - r_lo + SW'(1);
    end

    // control part of the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_bad   <= 1'b0;
        end else begin
            r_a_vld <= i_cmd.conv;
            r_b_vld <= r_a_vld;
            if (i_cmd.load) begin
                r_bad <= 1'b0;
            end else if (r_b_vld && !w_ok) begin
                r_bad <= 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_date[0] <= i_date0;
            r_date[1] <= i_date1;
            r_date[2] <= i_date2;
            r_date[3] <= i_date3;
        end
        r_a_idx   <= i_cmd.idx;
        r_a_date  <= w_sel;
        r_a_prodp <= PW'(w_q4p) * PW'(dpod_pkg::RECIP_25);
        r_a_prody <= PW'(w_q4y) * PW'(dpod_pkg::RECIP_25);
        r_b_idx   <= r_a_idx;
        r_b_date  <= r_a_date;
        r_b_base  <= w_base[SW-1:0];
        r_b_leap  <= w_leap;
        if (r_b_vld) begin
            r_ser[r_b_idx] <= w_serial;
        end
        if (i_cmd.window) begin
            r_lo <= (r_ser[0] > r_ser[2]) ? r_ser[0] : r_ser[2];
            r_hi <= (r_ser[1] < r_ser[3]) ? r_ser[1] : r_ser[3];
        end
        if (i_cmd.finish) begin
            if (r_bad) begin
                o_overlap_days <= '0;
                o_has_overlap  <= 1'b0;
                o_date_invalid <= 1'b1;
            end else if (r_lo <= r_hi) begin
                o_overlap_days <= w_diff;
                o_has_overlap  <= 1'b1;
                o_date_invalid <= 1'b0;
            end else begin
                o_overlap_days <= '0;
                o_has_overlap  <= 1'b0;
                o_date_invalid <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/core/date_period_overlap_days_top.sv =====
// Top level of the date period overlap block: sequencer and datapath.
// Give two date periods (first and second, each a start and an end date as
// year, month and day) and pulse start while busy is low; the dates are
// sampled at that edge. busy then stays high until the word appears on the
// o_ result ports, marked by o_done for exactly one cycle. The receiver
// cannot stall: take the word in that cycle; the result ports hold it until
// the next result replaces them. The word passes through the single
// serial-day converter, a three-stage pipeline that takes the four dates one
// per cycle and then drains, then through a register that forms the shared
// window and one that forms the result.
// busy falls as o_done rises, so a new start may be given in the o_done
// cycle. o_overlap_days counts the shared days, both ends included;
// o_has_overlap marks a non-empty window; o_date_invalid flags a year outside
// 1..9999, a month outside 1..12 or a day of 0 or past its month's end, and
// then forces the other two to zero.
module date_period_overlap_days_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [dpod_pkg::YEAR_W-1:0]       i_first_start_year,
    input  logic [dpod_pkg::MONTH_W-1:0]      i_first_start_month,
    input  logic [dpod_pkg::DAY_W-1:0]        i_first_start_day,
    input  logic [dpod_pkg::YEAR_W-1:0]       i_first_end_year,
    input  logic [dpod_pkg::MONTH_W-1:0]      i_first_end_month,
    input  logic [dpod_pkg::DAY_W-1:0]        i_first_end_day,
    input  logic [dpod_pkg::YEAR_W-1:0]       i_second_start_year,
    input  logic [dpod_pkg::MONTH_W-1:0]      i_second_start_month,
    input  logic [dpod_pkg::DAY_W-1:0]        i_second_start_day,
    input  logic [dpod_pkg::YEAR_W-1:0]       i_second_end_year,
    input  logic [dpod_pkg::MONTH_W-1:0]      i_second_end_month,
    input  logic [dpod_pkg::DAY_W-1:0]        i_second_end_day,
    output logic                              o_done,
    output logic [dpod_pkg::SER_W-1:0]        o_overlap_days,
    output logic                              o_has_overlap,
    output logic                              o_date_invalid
);

    dpod_pkg::t_cmd  w_cmd;
    dpod_pkg::t_date w_d0, w_d1, w_d2, w_d3;

    // order the dates as first start, first end, second start, second end
    assign w_d0 = '{year: i_first_start_year,  month: i_first_start_month,
                    day: i_first_start_day};
    assign w_d1 = '{year: i_first_end_year,    month: i_first_end_month,
                    day: i_first_end_day};
    assign w_d2 = '{year: i_second_start_year, month: i_second_start_month,
                    day: i_second_start_day};
    assign w_d3 = '{year: i_second_end_year,   month: i_second_end_month,
                    day: i_second_end_day};

    dpod_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_done  (o_done),
        .o_cmd   (w_cmd)
    );

    dpod_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_date0        (w_d0),
        .i_date1        (w_d1),
        .i_date2        (w_d2),
        .i_date3        (w_d3),
        .o_overlap_days (o_overlap_days),
        .o_has_overlap  (o_has_overlap),
        .o_date_invalid (o_date_invalid)
    );

    // an accepted word always yields its result strobe
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##9 o_done)
        else $error("result strobe missing after accepted word");

    // the result strobe comes only once the block has gone idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // an invalid date forces an empty result
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_date_invalid) |-> (o_overlap_days == '0) && !o_has_overlap)
        else $error("invalid date with non-zero overlap");

    // a non-empty window covers at least one day
    a_overlap_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_has_overlap) |-> (o_overlap_days != '0) && !o_date_invalid)
        else $error("overlap flagged with no days");

endmodule
